// File: hdl/rts_pkg.sv
// Package for the repeating timer scheduler: opcodes, result codes,
// cell commands, controller states and default sizes. No dependencies.
package rts_pkg;

  localparam int RTS_SLOTS       = 16;
  localparam int RTS_TIME_BITS   = 48;
  localparam int RTS_MAX_RESULTS = 16;
  localparam int RTS_ID_BITS     = 32;
  localparam int RTS_PER_BITS    = 32;
  localparam int RTS_REP_BITS    = 16;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_FIRED     = 3'd0,
    ST_START_OK  = 3'd1,
    ST_FULL      = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_TICK_INIT,
    CMD_START,
    CMD_CANCEL,
    CMD_FIRE
  } cell_op_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_INIT,
    FSM_WAIT
  } fsm_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [RTS_ID_BITS-1:0]   id;
    logic [RTS_PER_BITS-1:0]  period;
    logic [RTS_REP_BITS-1:0]  rep;
  } cmd_t;

endpackage

// File: hdl/rts_cell.sv
// One timer slot of the scheduler chain: holds the slot state and
// passes the running search result (id match, free slot, earliest due) on.
// Depends on rts_pkg.
module rts_cell #(
  parameter int SLOTS     = rts_pkg::RTS_SLOTS,
  parameter int TIME_BITS = rts_pkg::RTS_TIME_BITS,
  parameter int CELL_IDX  = 0
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  rts_pkg::cmd_t                           cmd_i,
  input  logic [$clog2(SLOTS)-1:0]                cmd_idx_i,
  input  logic [TIME_BITS-1:0]                    now_i,
  input  logic [3+3*$clog2(SLOTS)+TIME_BITS-1:0]  chain_i,
  output logic [3+3*$clog2(SLOTS)+TIME_BITS-1:0]  chain_o,
  output logic [rts_pkg::RTS_ID_BITS-1:0]         id_o
);
  import rts_pkg::*;

  localparam int IW    = $clog2(SLOTS);
  localparam int SUM_W = ((TIME_BITS > RTS_PER_BITS) ? TIME_BITS : RTS_PER_BITS) + 1;

  typedef struct packed {
    logic                 m_found;
    logic [IW-1:0]        m_idx;
    logic                 f_found;
    logic [IW-1:0]        f_idx;
    logic                 b_found;
    logic [TIME_BITS-1:0] b_due;
    logic [IW-1:0]        b_idx;
  } chain_t;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [RTS_PER_BITS-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'({TIME_BITS{1'b1}})) return {TIME_BITS{1'b1}};
    return TIME_BITS'(s);
  endfunction

  logic                    valid_r, valid_nxt;
  logic                    done_r, done_nxt;
  logic [RTS_ID_BITS-1:0]  id_r, id_nxt;
  logic [TIME_BITS-1:0]    due_r, due_nxt;
  logic [RTS_PER_BITS-1:0] per_r, per_nxt;
  logic [RTS_REP_BITS-1:0] rep_r, rep_nxt;
  chain_t                  chain_in, chain_r, chain_nxt;
  logic                    sel, eligible;

  assign chain_in = chain_i;
  assign chain_o  = chain_r;
  assign id_o     = id_r;
  assign sel      = (cmd_idx_i == IW'(CELL_IDX));
  assign eligible = valid_r && !done_r && (due_r <= now_i);

  always_comb begin
    chain_nxt = chain_in;
    if (!chain_in.m_found && valid_r && id_r == cmd_i.id) begin
      chain_nxt.m_found = 1'b1;
      chain_nxt.m_idx   = IW'(CELL_IDX);
    end
    if (!chain_in.f_found && !valid_r) begin
      chain_nxt.f_found = 1'b1;
      chain_nxt.f_idx   = IW'(CELL_IDX);
    end
    // strict compare keeps the lower slot on ties
    if (eligible && (!chain_in.b_found || due_r < chain_in.b_due)) begin
      chain_nxt.b_found = 1'b1;
      chain_nxt.b_due   = due_r;
      chain_nxt.b_idx   = IW'(CELL_IDX);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    done_nxt  = done_r;
    id_nxt    = id_r;
    due_nxt   = due_r;
    per_nxt   = per_r;
    rep_nxt   = rep_r;
    unique case (cmd_i.op)
      CMD_TICK_INIT: begin
        done_nxt = 1'b0;
        if (valid_r && due_r == '0) valid_nxt = 1'b0;
      end
      CMD_START: if (sel) begin
        valid_nxt = 1'b1;
        done_nxt  = 1'b0;
        id_nxt    = cmd_i.id;
        due_nxt   = sat_add(now_i, cmd_i.period);
        per_nxt   = cmd_i.period;
        rep_nxt   = cmd_i.rep;
      end
      CMD_CANCEL: if (sel) valid_nxt = 1'b0;
      CMD_FIRE: if (sel) begin
        done_nxt = 1'b1;
        if (rep_r == '0 || per_r == '0) begin
          valid_nxt = 1'b0;
        end else begin
          rep_nxt = rep_r - 1'b1;
          if (rep_r == RTS_REP_BITS'(1)) valid_nxt = 1'b0;
          else due_nxt = sat_add(now_i, per_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
    end
    id_r    <= id_nxt;
    due_r   <= due_nxt;
    per_r   <= per_nxt;
    rep_r   <= rep_nxt;
    chain_r <= chain_nxt;
  end

endmodule

// File: hdl/repeating_timer_scheduler.sv
// Repeating timer scheduler: a chain of SLOTS timer cells searched by a
// wave that moves one cell per cycle; in_ready is low until an item is done.
// Start and cancel: one search per item, one result.
// Tick: one search, plus another search per fired timer (up to 16).
// Reset (rst_n low, synchronous) empties every slot and clears control.
module repeating_timer_scheduler #(
  parameter int SLOTS     = rts_pkg::RTS_SLOTS,
  parameter int TIME_BITS = rts_pkg::RTS_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_opcode,
  input  logic [TIME_BITS-1:0] in_now_time,
  input  logic [31:0]          in_timer_id,
  input  logic [31:0]          in_period,
  input  logic [15:0]          in_repeat_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [31:0]          out_fired_id,
  output logic                 out_last
);
  import rts_pkg::*;

  localparam int IW   = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int FW   = $clog2(RTS_MAX_RESULTS + 1);
  localparam int CH_W = 3 + 3 * IW + TIME_BITS;

  typedef struct packed {
    logic                 m_found;
    logic [IW-1:0]        m_idx;
    logic                 f_found;
    logic [IW-1:0]        f_idx;
    logic                 b_found;
    logic [TIME_BITS-1:0] b_due;
    logic [IW-1:0]        b_idx;
  } chain_t;

  fsm_t                    state_r, state_nxt;
  logic [CW-1:0]           wait_cnt_r, wait_cnt_nxt;
  logic [FW-1:0]           fire_cnt_r, fire_cnt_nxt;
  opcode_t                 op_r;
  logic [TIME_BITS-1:0]    now_r;
  logic [31:0]             id_r, per_r;
  logic [15:0]             rep_r;
  logic                    pend_r, pend_nxt;
  logic [31:0]             pend_id_r, pend_id_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [2:0]              out_status_r, out_status_nxt;
  logic [31:0]             out_id_r, out_id_nxt;
  logic                    out_last_r, out_last_nxt;
  cmd_t                    cmd;
  logic [IW-1:0]           cmd_idx;
  logic [CH_W-1:0]         link [SLOTS+1];
  logic [31:0]             slot_ids [SLOTS];
  chain_t                  scan;
  logic                    accept, out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == FSM_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign link[0]  = '0;
  assign scan     = link[SLOTS];

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    rts_cell #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .CELL_IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd_i    (cmd),
      .cmd_idx_i(cmd_idx),
      .now_i    (now_r),
      .chain_i  (link[k]),
      .chain_o  (link[k+1]),
      .id_o     (slot_ids[k])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    wait_cnt_nxt   = wait_cnt_r;
    fire_cnt_nxt   = fire_cnt_r;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    cmd.op         = CMD_IDLE;
    cmd.id         = id_r;
    cmd.period     = per_r;
    cmd.rep        = rep_r;
    cmd_idx        = '0;
    unique case (state_r)
      FSM_IDLE: begin
        if (accept && opcode_t'(in_opcode) != OP_NONE) state_nxt = FSM_INIT;
      end
      FSM_INIT: begin
        if (op_r == OP_TICK) cmd.op = CMD_TICK_INIT;
        wait_cnt_nxt = '0;
        fire_cnt_nxt = '0;
        pend_nxt     = 1'b0;
        state_nxt    = FSM_WAIT;
      end
      FSM_WAIT: begin
        if (wait_cnt_r != CW'(SLOTS)) begin
          wait_cnt_nxt = wait_cnt_r + 1'b1;
        end else if (out_free) begin
          // chain end now reflects the current slot state
          priority case (op_r)
            OP_TICK: begin
              if (scan.b_found && fire_cnt_r != FW'(RTS_MAX_RESULTS)) begin
                cmd.op       = CMD_FIRE;
                cmd_idx      = scan.b_idx;
                fire_cnt_nxt = fire_cnt_r + 1'b1;
                pend_nxt     = 1'b1;
                pend_id_nxt  = slot_ids[scan.b_idx];
                wait_cnt_nxt = '0;
                if (pend_r) begin
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ST_FIRED;
                  out_id_nxt     = pend_id_r;
                  out_last_nxt   = 1'b0;
                end
              end else begin
                if (pend_r) begin
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ST_FIRED;
                  out_id_nxt     = pend_id_r;
                  out_last_nxt   = 1'b1;
                end
                pend_nxt  = 1'b0;
                state_nxt = FSM_IDLE;
              end
            end
            OP_START: begin
              out_valid_nxt = 1'b1;
              out_id_nxt    = id_r;
              out_last_nxt  = 1'b1;
              if (scan.m_found || scan.f_found) begin
                cmd.op         = CMD_START;
                cmd_idx        = scan.m_found ? scan.m_idx : scan.f_idx;
                out_status_nxt = ST_START_OK;
              end else begin
                out_status_nxt = ST_FULL;
              end
              state_nxt = FSM_IDLE;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_id_nxt    = id_r;
              out_last_nxt  = 1'b1;
              if (scan.m_found) begin
                cmd.op         = CMD_CANCEL;
                cmd_idx        = scan.m_idx;
                out_status_nxt = ST_CANCELLED;
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
              state_nxt = FSM_IDLE;
            end
          endcase
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      wait_cnt_r  <= '0;
      fire_cnt_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      op_r  <= opcode_t'(in_opcode);
      now_r <= in_now_time;
      id_r  <= in_timer_id;
      per_r <= in_period;
      rep_r <= in_repeat_count;
    end
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_fired_id = out_id_r;
  assign out_last     = out_last_r;

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept && opcode_t'(in_opcode) != OP_NONE |=> state_r == FSM_INIT)
    else $error("accepted item did not start a search");

  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= FW'(RTS_MAX_RESULTS))
    else $error("fire count beyond result limit");

  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wait_cnt_r <= CW'(SLOTS))
    else $error("search wait counter overran");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_IDLE |-> !pend_r)
    else $error("fired timer left unreported");

endmodule
